// ===== rtl/hop_pkg.sv =====
// ----------------------------------------------------------------------------
// hop_pkg
// Shared types and codes for the Hopfield associative memory.
// ----------------------------------------------------------------------------
package hop_pkg;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_TRAIN  = 2'd1;
  localparam logic [1:0] OP_RECALL = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam int CFG_W  = 7;
  localparam int PASS_W = 7;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRAIN,
    ST_PASS_START,
    ST_RECALL,
    ST_PASS_END,
    ST_PASS_CHK,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/hop_in_if.sv =====
// ----------------------------------------------------------------------------
// hop_in_if
// Input channel: opcode and pattern bit per transaction.
// ----------------------------------------------------------------------------
interface hop_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       pixel_bit;
  logic       last_bit;

  modport source (output valid, opcode, pixel_bit, last_bit, input ready);
  modport sink   (input valid, opcode, pixel_bit, last_bit, output ready);
endinterface

// ===== rtl/hop_out_if.sv =====
// ----------------------------------------------------------------------------
// hop_out_if
// Output channel: one recalled neuron per transaction.
// ----------------------------------------------------------------------------
interface hop_out_if;
  logic       valid;
  logic       ready;
  logic       out_bit;
  logic       last_out;
  logic       converged;
  logic [6:0] passes_used;

  modport source (output valid, out_bit, last_out, converged, passes_used, input ready);
  modport sink   (input valid, out_bit, last_out, converged, passes_used, output ready);
endinterface

// ===== rtl/hop_ram.sv =====
// ----------------------------------------------------------------------------
// hop_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hop_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hopfield_associative_memory_top.sv =====
// ----------------------------------------------------------------------------
// hopfield_associative_memory_top
// Binary Hopfield memory with Hebbian training and synchronous recall.
//
// in_ch carries one pattern bit per transaction: clear, train or probe.
// out_ch returns one recalled neuron per transaction after a probe's last bit.
// cfg_wr_en / cfg_wr_data set pattern_length (neurons in use).
// Weights live in one RAM, lower triangle only, address {row, column}.
// A train bit at position i > 0 updates its i weights, one weight per cycle
// (read then saturating write-back, pipelined on the two RAM ports).
// A recall pass reads n*n weights, one weight read per cycle; up to n+1
// passes run, then n results leave at one per cycle while the receiver is ready.
// Reset and the clear opcode sweep the whole weight RAM, one entry per cycle
// (MAX_NEURONS rounded to a power of two, squared); in_ch is not ready then.
// in_ch is also not ready during training, recall and result delivery.
// Results sit in an output register; a stalled receiver holds the sweep of
// results, and in_ch reopens while the last result still waits.
// ----------------------------------------------------------------------------
module hopfield_associative_memory_top #(
  parameter int MAX_NEURONS = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [hop_pkg::CFG_W-1:0] cfg_wr_data,
  hop_in_if.sink                    in_ch,
  hop_out_if.source                 out_ch
);

  localparam int IW    = $clog2(MAX_NEURONS);
  localparam int NW    = $clog2(MAX_NEURONS + 1);
  localparam int AW    = 2 * IW;
  localparam int LW    = (NW > hop_pkg::CFG_W) ? NW : hop_pkg::CFG_W;
  localparam int PW    = (NW + 1 > hop_pkg::PASS_W) ? NW + 1 : hop_pkg::PASS_W;
  localparam int ACC_W = WEIGHT_BITS + IW + 1;

  hop_pkg::state_t state, state_next;

  logic [hop_pkg::CFG_W-1:0] len;
  logic [NW-1:0]             n, nm1;
  logic [MAX_NEURONS-1:0]    buf_q, prev;
  logic [NW-1:0]             pos;
  logic [NW-1:0]             ti, tj;
  logic                      tbit, tlast, t_pend;
  logic [IW-1:0]             t_j;
  logic [AW-1:0]             caddr;
  logic [NW-1:0]             ri, rj, e_idx;
  logic                      p_valid, p_last;
  logic [IW-1:0]             p_i, p_j;
  logic signed [ACC_W-1:0]   acc, term, sum;
  logic                      changed;
  logic [PW-1:0]             passes;
  logic                      conv;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr, ram_raddr;
  logic [WEIGHT_BITS-1:0]    ram_wdata, ram_rdata;
  logic signed [WEIGHT_BITS-1:0] rdata_s;
  logic signed [WEIGHT_BITS:0]   tsum;
  logic [NW-1:0]             rhi, rlo;

  logic in_acc, take_bit, out_load, issue_done, keep_going;

  hop_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(1 << AW)) u_wram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // effective neuron count
  always_comb begin
    if (len == '0) begin
      n = NW'(1);
    end else if (LW'(len) > LW'(MAX_NEURONS)) begin
      n = NW'(MAX_NEURONS);
    end else begin
      n = NW'(len);
    end
  end
  assign nm1 = n - NW'(1);

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign take_bit   = (in_ch.opcode == hop_pkg::OP_TRAIN || in_ch.opcode == hop_pkg::OP_RECALL)
                      && (pos < n);
  assign out_load   = (state == hop_pkg::ST_EMIT) && (!out_ch.valid || out_ch.ready);
  assign issue_done = (ri == nm1) && (rj == nm1);
  assign keep_going = changed && ((passes + PW'(1)) <= PW'(n));

  // saturating hebbian update
  assign rdata_s = ram_rdata;
  always_comb begin
    if (buf_q[t_j] == tbit) begin
      tsum = {rdata_s[WEIGHT_BITS-1], rdata_s} + (WEIGHT_BITS+1)'(1);
    end else begin
      tsum = {rdata_s[WEIGHT_BITS-1], rdata_s} - (WEIGHT_BITS+1)'(1);
    end
  end

  // recall accumulate
  always_comb begin
    if (prev[p_j]) begin
      term = ACC_W'(rdata_s);
    end else begin
      term = -ACC_W'(rdata_s);
    end
    sum = ((p_j == '0) ? '0 : acc) + term;
  end

  assign rhi = (ri > rj) ? ri : rj;
  assign rlo = (ri > rj) ? rj : ri;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hop_pkg::ST_CLEAR: begin
        if (&caddr) state_next = hop_pkg::ST_IDLE;
      end
      hop_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.opcode == hop_pkg::OP_CLEAR) begin
            state_next = hop_pkg::ST_CLEAR;
          end else if (in_ch.opcode == hop_pkg::OP_TRAIN) begin
            if (take_bit && pos != '0) state_next = hop_pkg::ST_TRAIN;
          end else if (in_ch.opcode == hop_pkg::OP_RECALL) begin
            if (in_ch.last_bit) state_next = hop_pkg::ST_PASS_START;
          end
        end
      end
      hop_pkg::ST_TRAIN: begin
        if (tj >= ti && !t_pend) state_next = hop_pkg::ST_IDLE;
      end
      hop_pkg::ST_PASS_START: state_next = hop_pkg::ST_RECALL;
      hop_pkg::ST_RECALL: begin
        if (issue_done) state_next = hop_pkg::ST_PASS_END;
      end
      hop_pkg::ST_PASS_END: state_next = hop_pkg::ST_PASS_CHK;
      hop_pkg::ST_PASS_CHK: begin
        state_next = keep_going ? hop_pkg::ST_PASS_START : hop_pkg::ST_EMIT;
      end
      hop_pkg::ST_EMIT: begin
        if (out_load && e_idx == nm1) state_next = hop_pkg::ST_IDLE;
      end
      default: state_next = hop_pkg::ST_IDLE;
    endcase
  end

  // outputs and ram control
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = {ti[IW-1:0], t_j};
    ram_wdata   = tsum[WEIGHT_BITS-1:0];
    ram_raddr   = {ti[IW-1:0], tj[IW-1:0]};
    case (state)
      hop_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = caddr;
        ram_wdata = '0;
      end
      hop_pkg::ST_IDLE: in_ch.ready = 1'b1;
      hop_pkg::ST_TRAIN: begin
        ram_we = t_pend;
        if (tsum[WEIGHT_BITS] != tsum[WEIGHT_BITS-1]) begin
          ram_wdata = {tsum[WEIGHT_BITS], {(WEIGHT_BITS-1){~tsum[WEIGHT_BITS]}}};
        end
      end
      hop_pkg::ST_RECALL: ram_raddr = {rhi[IW-1:0], rlo[IW-1:0]};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hop_pkg::ST_CLEAR;
      len           <= hop_pkg::CFG_W'(64);
      buf_q         <= '0;
      pos           <= '0;
      caddr         <= '0;
      t_pend        <= 1'b0;
      p_valid       <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) len <= cfg_wr_data;
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      p_valid <= 1'b0;
      t_pend  <= 1'b0;

      case (state)
        hop_pkg::ST_CLEAR: caddr <= caddr + AW'(1);
        hop_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.opcode == hop_pkg::OP_CLEAR) begin
              buf_q <= '0;
              pos   <= '0;
              caddr <= '0;
            end else if (in_ch.opcode != hop_pkg::OP_NONE) begin
              if (take_bit) begin
                buf_q[pos[IW-1:0]] <= in_ch.pixel_bit;
                pos <= pos + NW'(1);
              end
              ti    <= pos;
              tj    <= '0;
              tbit  <= in_ch.pixel_bit;
              tlast <= in_ch.last_bit;
              passes <= '0;
              if (in_ch.opcode == hop_pkg::OP_TRAIN && in_ch.last_bit
                  && !(take_bit && pos != '0)) begin
                buf_q <= '0;
                pos   <= '0;
              end
            end
          end
        end
        hop_pkg::ST_TRAIN: begin
          if (tj < ti) begin
            t_pend <= 1'b1;
            t_j    <= tj[IW-1:0];
            tj     <= tj + NW'(1);
          end else if (!t_pend && tlast) begin
            buf_q <= '0;
            pos   <= '0;
          end
        end
        hop_pkg::ST_PASS_START: begin
          prev    <= buf_q;
          ri      <= '0;
          rj      <= '0;
          changed <= 1'b0;
        end
        hop_pkg::ST_RECALL: begin
          p_valid <= 1'b1;
          p_i     <= ri[IW-1:0];
          p_j     <= rj[IW-1:0];
          p_last  <= (rj == nm1);
          if (rj == nm1) begin
            rj <= '0;
            ri <= ri + NW'(1);
          end else begin
            rj <= rj + NW'(1);
          end
        end
        hop_pkg::ST_PASS_CHK: begin
          passes <= passes + PW'(1);
          conv   <= !changed;
          e_idx  <= '0;
        end
        hop_pkg::ST_EMIT: begin
          if (out_load) begin
            out_ch.valid       <= 1'b1;
            out_ch.out_bit     <= buf_q[e_idx[IW-1:0]];
            out_ch.last_out    <= (e_idx == nm1);
            out_ch.converged   <= conv;
            out_ch.passes_used <= passes[hop_pkg::PASS_W-1:0];
            e_idx              <= e_idx + NW'(1);
            if (e_idx == nm1) begin
              buf_q <= '0;
              pos   <= '0;
            end
          end
        end
        default: ;
      endcase

      // recall read data returns in the cycle after issue
      if (p_valid) begin
        acc <= sum;
        if (p_last) begin
          buf_q[p_i] <= ~sum[ACC_W-1];
          if (~sum[ACC_W-1] != prev[p_i]) changed <= 1'b1;
        end
      end
    end
  end

endmodule
